// ===== sv/vrot_pkg.sv =====
package vrot_pkg;

  // Fixed field widths.
  localparam int COORD_W = 24;
  localparam int ANGLE_W = 19;

  // Defaults for the top-level parameters.
  localparam int SERIES_TERMS_DEF  = 4;
  localparam int FRACTION_BITS_DEF = 16;

  // Integer bits (with sign) of the series terms and partial sums.
  localparam int GUARD_W = 5;

  // Integer bits of a term product before it is divided by its constant.
  localparam int TERM_MAG_W = 7;

  // Extra shift of the reciprocal constants beyond the fraction bits.
  localparam int RECIP_SHIFT_X = 16;

  // Pi with 30 fraction bits.
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vertex_t;

endpackage

// ===== sv/vrot_sincos.sv =====
module vrot_sincos #(
  parameter int SERIES_TERMS  = vrot_pkg::SERIES_TERMS_DEF,
  parameter int FRACTION_BITS = vrot_pkg::FRACTION_BITS_DEF
) (
  input  logic                                                  clk_i,
  input  logic [2*SERIES_TERMS+1:0]                             en_i,
  input  logic signed [vrot_pkg::ANGLE_W-1:0]                   angle_i,
  output logic signed [FRACTION_BITS+vrot_pkg::GUARD_W-1:0]     sin_o,
  output logic signed [FRACTION_BITS+vrot_pkg::GUARD_W-1:0]     cos_o
);

  localparam int F   = FRACTION_BITS;
  localparam int TW  = F + vrot_pkg::GUARD_W;
  localparam int AW  = vrot_pkg::ANGLE_W;
  localparam int SQW = 2 * AW;
  localparam int PW  = 2 * TW;
  localparam int MW  = F + vrot_pkg::TERM_MAG_W;
  localparam int KS  = F + vrot_pkg::RECIP_SHIFT_X;
  localparam int RW  = KS;
  localparam int FIN = 2 * SERIES_TERMS + 1;
  localparam longint PiRaw =
      longint'((vrot_pkg::PI_Q30 + (64'd1 << (29 - F))) >> (30 - F));
  localparam logic signed [TW-1:0] One = TW'(longint'(1) << F);

  // Stage 0: clamp the angle to plus or minus pi and square it.
  logic signed [31:0]    a_wide;
  logic signed [AW-1:0]  a_clip;
  logic signed [SQW-1:0] sq;
  logic signed [SQW:0]   sq_rnd;
  logic signed [TW-1:0]  a_q, x2_q;

  always_comb begin
    a_wide = 32'(angle_i);
    if (a_wide > 32'(PiRaw)) begin
      a_clip = AW'(PiRaw);
    end else if (a_wide < -32'(PiRaw)) begin
      a_clip = AW'(-PiRaw);
    end else begin
      a_clip = angle_i;
    end
    sq     = a_clip * a_clip;
    sq_rnd = (SQW+1)'(sq) + (SQW+1)'(longint'(1) << (F - 1));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      a_q  <= TW'(a_clip);
      x2_q <= TW'(sq_rnd >>> F);
    end
  end

  // Running term and partial sum that enter each term step.
  logic signed [TW-1:0] t_s [SERIES_TERMS+1:1];
  logic signed [TW-1:0] r_s [SERIES_TERMS+1:1];
  logic signed [TW-1:0] t_c [SERIES_TERMS+1:1];
  logic signed [TW-1:0] r_c [SERIES_TERMS+1:1];
  logic signed [TW-1:0] x2_in [SERIES_TERMS:1];

  assign t_s[1]   = a_q;
  assign r_s[1]   = a_q;
  assign t_c[1]   = One;
  assign r_c[1]   = One;
  assign x2_in[1] = x2_q;

  // Each term takes two stages: the product with x squared, then the
  // rounded division by its constant through a reciprocal multiply.
  for (genvar n = 1; n <= SERIES_TERMS; n++) begin : g_term
    localparam longint unsigned Ds = 64'(2 * n * (2 * n + 1));
    localparam longint unsigned Dc = 64'((2 * n - 1) * (2 * n));
    localparam longint unsigned Rs = ((64'd1 << KS) + Ds - 1) / Ds;
    localparam longint unsigned Rc = ((64'd1 << KS) + Dc - 1) / Dc;
    localparam longint unsigned HalfS = Ds / 2;
    localparam longint unsigned HalfC = Dc / 2;

    logic signed [PW-1:0] pa_s_q, pa_c_q;
    logic signed [TW-1:0] ra_s_q, ra_c_q;
    logic signed [PW:0]   rnd_s, rnd_c;
    logic signed [PW-F:0] n_s, n_c;
    logic [MW-1:0]        m_s, m_c;
    logic [MW+RW-1:0]     prod_s, prod_c;
    logic [TW-1:0]        q_s_q, q_c_q;
    logic                 neg_s_q, neg_c_q;
    logic signed [TW-1:0] rb_s_q, rb_c_q;

    // Product stage.
    always_ff @(posedge clk_i) begin
      if (en_i[2*n-1]) begin
        pa_s_q <= t_s[n] * x2_in[n];
        pa_c_q <= t_c[n] * x2_in[n];
        ra_s_q <= r_s[n];
        ra_c_q <= r_c[n];
      end
    end

    // Round the product, take its magnitude and divide by the constant.
    always_comb begin
      rnd_s  = (PW+1)'(pa_s_q) + (PW+1)'(longint'(1) << (F - 1));
      rnd_c  = (PW+1)'(pa_c_q) + (PW+1)'(longint'(1) << (F - 1));
      n_s    = (PW-F+1)'(rnd_s >>> F);
      n_c    = (PW-F+1)'(rnd_c >>> F);
      m_s    = (n_s[PW-F] ? MW'(-n_s) : MW'(n_s)) + MW'(HalfS);
      m_c    = (n_c[PW-F] ? MW'(-n_c) : MW'(n_c)) + MW'(HalfC);
      prod_s = (MW+RW)'(m_s) * (MW+RW)'(Rs);
      prod_c = (MW+RW)'(m_c) * (MW+RW)'(Rc);
    end

    always_ff @(posedge clk_i) begin
      if (en_i[2*n]) begin
        q_s_q   <= TW'(prod_s >> KS);
        q_c_q   <= TW'(prod_c >> KS);
        neg_s_q <= n_s[PW-F];
        neg_c_q <= n_c[PW-F];
        rb_s_q  <= ra_s_q;
        rb_c_q  <= ra_c_q;
      end
    end

    // The new term carries the opposite sign of the rounded product.
    assign t_s[n+1] = neg_s_q ? signed'(q_s_q) : -signed'(q_s_q);
    assign t_c[n+1] = neg_c_q ? signed'(q_c_q) : -signed'(q_c_q);
    assign r_s[n+1] = rb_s_q + t_s[n+1];
    assign r_c[n+1] = rb_c_q + t_c[n+1];

    // x squared travels along with the terms that still need it.
    if (n < SERIES_TERMS) begin : g_x2
      logic signed [TW-1:0] x2a_q, x2b_q;

      always_ff @(posedge clk_i) begin
        if (en_i[2*n-1]) begin
          x2a_q <= x2_in[n];
        end
        if (en_i[2*n]) begin
          x2b_q <= x2a_q;
        end
      end

      assign x2_in[n+1] = x2b_q;
    end
  end

  // Final stage registers the complete sums.
  logic signed [TW-1:0] sin_q, cos_q;

  always_ff @(posedge clk_i) begin
    if (en_i[FIN]) begin
      sin_q <= r_s[SERIES_TERMS+1];
      cos_q <= r_c[SERIES_TERMS+1];
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// ===== sv/vrot_rotate.sv =====
module vrot_rotate #(
  parameter int FRACTION_BITS = vrot_pkg::FRACTION_BITS_DEF,
  parameter int SIDE_W        = vrot_pkg::COORD_W
) (
  input  logic                                              clk_i,
  input  logic [1:0]                                        en_i,
  input  vrot_pkg::coord_t                                  p_i,
  input  vrot_pkg::coord_t                                  q_i,
  input  logic signed [FRACTION_BITS+vrot_pkg::GUARD_W-1:0] s_i,
  input  logic signed [FRACTION_BITS+vrot_pkg::GUARD_W-1:0] c_i,
  input  logic [SIDE_W-1:0]                                 side_i,
  output vrot_pkg::coord_t                                  p_o,
  output vrot_pkg::coord_t                                  q_o,
  output logic [SIDE_W-1:0]                                 side_o
);

  localparam int F  = FRACTION_BITS;
  localparam int TW = F + vrot_pkg::GUARD_W;
  localparam int PM = vrot_pkg::COORD_W + TW;
  localparam logic signed [PM+1:0] CMax =
      (PM+2)'((longint'(1) << (vrot_pkg::COORD_W - 1)) - 1);
  localparam logic signed [PM+1:0] CMin = -CMax - 1;
  localparam logic signed [PM+1:0] Half = (PM+2)'(longint'(1) << (F - 1));

  // Stage 1: the four products.
  logic signed [PM-1:0] pc_q, qs_q, ps_q, qc_q;
  logic [SIDE_W-1:0]    side1_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pc_q    <= p_i * c_i;
      qs_q    <= q_i * s_i;
      ps_q    <= p_i * s_i;
      qc_q    <= q_i * c_i;
      side1_q <= side_i;
    end
  end

  // Stage 2: sum, round once and saturate.
  logic signed [PM+1:0] sp, sq;
  vrot_pkg::coord_t     p_d, q_d;

  always_comb begin
    sp = ((PM+2)'(pc_q) - (PM+2)'(qs_q) + Half) >>> F;
    sq = ((PM+2)'(ps_q) + (PM+2)'(qc_q) + Half) >>> F;
    if (sp > CMax) begin
      p_d = vrot_pkg::COORD_W'(CMax);
    end else if (sp < CMin) begin
      p_d = vrot_pkg::COORD_W'(CMin);
    end else begin
      p_d = vrot_pkg::COORD_W'(sp);
    end
    if (sq > CMax) begin
      q_d = vrot_pkg::COORD_W'(CMax);
    end else if (sq < CMin) begin
      q_d = vrot_pkg::COORD_W'(CMin);
    end else begin
      q_d = vrot_pkg::COORD_W'(sq);
    end
  end

  vrot_pkg::coord_t  p_q, q_q;
  logic [SIDE_W-1:0] side2_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      p_q     <= p_d;
      q_q     <= q_d;
      side2_q <= side1_q;
    end
  end

  assign p_o    = p_q;
  assign q_o    = q_q;
  assign side_o = side2_q;

endmodule

// ===== sv/three_axis_vertex_rotation_unit.sv =====
// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_stall_o   x_in_i y_in_i z_in_i angle_about_{x,y,z}_i
// output    out        out_valid_o / out_stall_i x_out_o y_out_o z_out_o
//
// One vertex is taken per cycle while in_stall_o is low. The pipeline has
// 2*SERIES_TERMS+8 stages, set by the 2*SERIES_TERMS+2 sine and cosine stages
// and the two stages of each of the three rotations; the first stage loads at
// the transfer edge.
// Reset clears only the stage valid bits; the data registers hold no reset.
// Each stage moves forward whenever the stage after it is empty or moving,
// so a stall at the output fills the bubbles before the input stalls.
module three_axis_vertex_rotation_unit #(
  parameter int SERIES_TERMS  = vrot_pkg::SERIES_TERMS_DEF,
  parameter int FRACTION_BITS = vrot_pkg::FRACTION_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [vrot_pkg::COORD_W-1:0] x_in_i,
  input  logic signed [vrot_pkg::COORD_W-1:0] y_in_i,
  input  logic signed [vrot_pkg::COORD_W-1:0] z_in_i,
  input  logic signed [vrot_pkg::ANGLE_W-1:0] angle_about_x_i,
  input  logic signed [vrot_pkg::ANGLE_W-1:0] angle_about_y_i,
  input  logic signed [vrot_pkg::ANGLE_W-1:0] angle_about_z_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [vrot_pkg::COORD_W-1:0] x_out_o,
  output logic signed [vrot_pkg::COORD_W-1:0] y_out_o,
  output logic signed [vrot_pkg::COORD_W-1:0] z_out_o
);

  localparam int TW  = FRACTION_BITS + vrot_pkg::GUARD_W;
  localparam int CW  = vrot_pkg::COORD_W;
  localparam int L1  = 2 * SERIES_TERMS + 2;
  localparam int N   = L1 + 6;
  localparam int SXW = CW + 4 * TW;
  localparam int SYW = CW + 2 * TW;

  // Valid bits and the per-stage advance chain.
  logic [N-1:0] v_q, v_d, rdy;

  always_comb begin
    rdy[N-1] = !v_q[N-1] || !out_stall_i;
    for (int k = N - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    v_d = {v_q[N-2:0], in_valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_d[k];
        end
      end
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = v_q[N-1];

  // Coordinates wait beside the series stages.
  vrot_pkg::vertex_t cd_q [L1];

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      cd_q[0] <= '{x: x_in_i, y: y_in_i, z: z_in_i};
    end
    for (int k = 1; k < L1; k++) begin
      if (rdy[k]) begin
        cd_q[k] <= cd_q[k-1];
      end
    end
  end

  // Sine and cosine of the three angles, side by side.
  logic signed [TW-1:0] sin_x, cos_x, sin_y, cos_y, sin_z, cos_z;

  vrot_sincos #(.SERIES_TERMS(SERIES_TERMS), .FRACTION_BITS(FRACTION_BITS)) u_sc_x (
    .clk_i, .en_i(rdy[L1-1:0]), .angle_i(angle_about_x_i), .sin_o(sin_x), .cos_o(cos_x)
  );
  vrot_sincos #(.SERIES_TERMS(SERIES_TERMS), .FRACTION_BITS(FRACTION_BITS)) u_sc_y (
    .clk_i, .en_i(rdy[L1-1:0]), .angle_i(angle_about_y_i), .sin_o(sin_y), .cos_o(cos_y)
  );
  vrot_sincos #(.SERIES_TERMS(SERIES_TERMS), .FRACTION_BITS(FRACTION_BITS)) u_sc_z (
    .clk_i, .en_i(rdy[L1-1:0]), .angle_i(angle_about_z_i), .sin_o(sin_z), .cos_o(cos_z)
  );

  // Rotation about X on (y, z); x and the later angles ride along.
  vrot_pkg::coord_t rx_p, rx_q;
  logic [SXW-1:0]   rx_side;

  vrot_rotate #(.FRACTION_BITS(FRACTION_BITS), .SIDE_W(SXW)) u_rot_x (
    .clk_i, .en_i(rdy[L1+1:L1]),
    .p_i(cd_q[L1-1].y), .q_i(cd_q[L1-1].z), .s_i(sin_x), .c_i(cos_x),
    .side_i({cd_q[L1-1].x, sin_y, cos_y, sin_z, cos_z}),
    .p_o(rx_p), .q_o(rx_q), .side_o(rx_side)
  );

  // Rotation about Y on (z, x).
  vrot_pkg::coord_t ry_p, ry_q;
  logic [SYW-1:0]   ry_side;

  vrot_rotate #(.FRACTION_BITS(FRACTION_BITS), .SIDE_W(SYW)) u_rot_y (
    .clk_i, .en_i(rdy[L1+3:L1+2]),
    .p_i(rx_q), .q_i(rx_side[SXW-1 -: CW]),
    .s_i(rx_side[4*TW-1 -: TW]), .c_i(rx_side[3*TW-1 -: TW]),
    .side_i({rx_p, rx_side[2*TW-1:0]}),
    .p_o(ry_p), .q_o(ry_q), .side_o(ry_side)
  );

  // Rotation about Z on (x, y); the result registers face the output.
  logic [CW-1:0] rz_side;

  vrot_rotate #(.FRACTION_BITS(FRACTION_BITS), .SIDE_W(CW)) u_rot_z (
    .clk_i, .en_i(rdy[L1+5:L1+4]),
    .p_i(ry_q), .q_i(ry_side[SYW-1 -: CW]),
    .s_i(ry_side[2*TW-1 -: TW]), .c_i(ry_side[TW-1:0]),
    .side_i(ry_p),
    .p_o(x_out_o), .q_o(y_out_o), .side_o(rz_side)
  );

  assign z_out_o = rz_side;

  // The input stalls only when every stage holds an item and the output waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_stall_o |-> ($countones(v_q) == N) && out_stall_i)
    else $error("input stalled while the pipeline has room");

  // An item in the last inner stage moves into the output when it may.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      v_q[N-2] && rdy[N-1] |=> out_valid_o)
    else $error("item lost on its way to the output");

  // A transfer at the input fills the first stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_valid_i && !in_stall_o |=> v_q[0])
    else $error("accepted vertex did not enter the pipeline");

endmodule
